// ----- sv/soft_viterbi_decoder_k7_defines.svh -----
// Assertion helpers for the soft Viterbi decoder checker.
`ifndef SOFT_VITERBI_DECODER_K7_DEFINES_SVH
`define SOFT_VITERBI_DECODER_K7_DEFINES_SVH

// Implication to the next cycle, masked while reset is asserted.
`define SVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svd check failed");

// Implication to the next cycle, checked during reset as well.
`define SVD_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("svd check failed");

`endif

// ----- sv/svd_pkg.sv -----
`default_nettype none
package svd_pkg;

    localparam int NSTATES = 64;

    typedef struct packed {
        logic [3:0] soft_first;
        logic [3:0] soft_second;
        logic       record_decisions;
    } t_in_word;

    typedef struct packed {
        logic decoded_bit;
        logic last_of_window;
    } t_out_word;

    // one recorded trellis step handed from ACS to traceback
    typedef struct packed {
        logic [NSTATES-1:0] row;
        logic [5:0]         best;
        logic               trig;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef enum logic [1:0] {
        F_IDLE,
        F_ACS,
        F_MIN,
        F_NORM
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TB_ADDR,
        B_TB_DATA,
        B_EM_ADDR,
        B_EM_LOAD
    } t_back_state;

    // branch index for input 0 out of predecessor j
    function automatic logic [1:0] bm_index(input logic [5:0] j);
        logic p0;
        logic p1;
        p0 = ^(j & 6'h27);
        p1 = ^(j & 6'h36);
        return {p1, p0};
    endfunction

endpackage
`default_nettype wire

// ----- sv/svd_front.sv -----
`default_nettype none
module svd_front #(
    parameter int METRIC_BITS = 11,
    parameter int RING_ROWS   = 128,
    parameter int EMIT_ROWS   = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire svd_pkg::t_in_word i_in,
    input  wire logic              i_q_full,
    output svd_pkg::t_push         o_push
);
    localparam int SB = METRIC_BITS + 1;
    localparam int CW = $clog2(RING_ROWS + 1);

    svd_pkg::t_front_state r_st, n_st;

    logic [METRIC_BITS-1:0] r_pm   [svd_pkg::NSTATES];
    logic [SB-1:0]          r_sum  [svd_pkg::NSTATES];
    logic [SB-1:0]          r_tree [svd_pkg::NSTATES];
    logic [svd_pkg::NSTATES-1:0] r_row;
    logic [3:0] r_r0, r_r1;
    logic       r_rec;
    logic [2:0] r_lvl;
    logic [CW-1:0] r_cnt;

    logic [4:0] w_bm [4];
    logic [SB-1:0] w_sum [svd_pkg::NSTATES];
    logic [svd_pkg::NSTATES-1:0] w_row;
    logic [5:0] w_best;
    logic       w_leave;
    logic       w_trig;
    logic [CW-1:0] w_cnt_inc;

    always_comb begin
        logic [1:0] ilo, ihi, slo, shi;
        logic [SB-1:0] a, c;
        w_bm[0] = 5'(r_r0) + 5'(r_r1);
        w_bm[1] = 5'd15 + 5'(r_r0) - 5'(r_r1);
        w_bm[2] = 5'd15 + 5'(r_r1) - 5'(r_r0);
        w_bm[3] = 5'd30 - 5'(r_r0) - 5'(r_r1);
        w_row = '0;
        for (int k = 0; k < 32; k++) begin
            ilo = svd_pkg::bm_index(6'(k));
            ihi = svd_pkg::bm_index(6'(k + 32));
            for (int b = 0; b < 2; b++) begin
                slo = (b == 1) ? 2'd3 - ilo : ilo;
                shi = (b == 1) ? 2'd3 - ihi : ihi;
                a = {1'b0, r_pm[k]} + SB'(w_bm[slo]);
                c = {1'b0, r_pm[k + 32]} + SB'(w_bm[shi]);
                if (a > c) begin
                    w_sum[2 * k + b] = c;
                    w_row[2 * k + b] = 1'b1;
                end else begin
                    w_sum[2 * k + b] = a;
                end
            end
        end
    end

    always_comb begin
        w_best = '0;
        for (int k = 0; k < svd_pkg::NSTATES; k++) begin
            if (r_sum[k] == r_tree[0]) w_best = w_best | 6'(k);
        end
    end

    assign w_cnt_inc = r_cnt + CW'(1);
    assign w_trig    = (w_cnt_inc >= CW'(RING_ROWS));
    assign w_leave   = !r_rec || !i_q_full;

    always_comb begin
        n_st = r_st;
        o_in_stall = (r_st != svd_pkg::F_IDLE);
        o_push.valid = 1'b0;
        o_push.job.row  = r_row;
        o_push.job.best = w_best;
        o_push.job.trig = w_trig;
        case (r_st)
            svd_pkg::F_IDLE: if (i_in_valid) n_st = svd_pkg::F_ACS;
            svd_pkg::F_ACS:  n_st = svd_pkg::F_MIN;
            svd_pkg::F_MIN:  if (r_lvl == 3'd5) n_st = svd_pkg::F_NORM;
            svd_pkg::F_NORM: begin
                if (w_leave) begin
                    o_push.valid = r_rec;
                    n_st = svd_pkg::F_IDLE;
                end
            end
            default: n_st = svd_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= svd_pkg::F_IDLE;
            r_cnt <= '0;
            r_lvl <= '0;
            for (int k = 0; k < svd_pkg::NSTATES; k++) r_pm[k] <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                svd_pkg::F_IDLE: r_lvl <= '0;
                svd_pkg::F_MIN:  r_lvl <= r_lvl + 3'd1;
                svd_pkg::F_NORM: begin
                    if (w_leave) begin
                        for (int k = 0; k < svd_pkg::NSTATES; k++)
                            r_pm[k] <= METRIC_BITS'(r_sum[k] - r_tree[0]);
                        if (r_rec)
                            r_cnt <= w_trig ? CW'(RING_ROWS - EMIT_ROWS) : w_cnt_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_st == svd_pkg::F_IDLE && i_in_valid) begin
            r_r0  <= i_in.soft_first;
            r_r1  <= i_in.soft_second;
            r_rec <= i_in.record_decisions;
        end
        if (r_st == svd_pkg::F_ACS) begin
            r_row <= w_row;
            for (int k = 0; k < svd_pkg::NSTATES; k++) begin
                r_sum[k]  <= w_sum[k];
                r_tree[k] <= w_sum[k];
            end
        end
        if (r_st == svd_pkg::F_MIN) begin
            // one level of the min tree per cycle, folded in place
            for (int i = 0; i < 32; i++)
                r_tree[i] <= (r_tree[2 * i + 1] < r_tree[2 * i]) ?
                             r_tree[2 * i + 1] : r_tree[2 * i];
        end
    end
endmodule
`default_nettype wire

// ----- sv/svd_queue.sv -----
`default_nettype none
module svd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire svd_pkg::t_push i_push,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output svd_pkg::t_job       o_job
);
    svd_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_wr    = i_push.valid && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_push.job;
    end
endmodule
`default_nettype wire

// ----- sv/svd_back.sv -----
`default_nettype none
module svd_back #(
    parameter int RING_ROWS = 128,
    parameter int EMIT_ROWS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire svd_pkg::t_job      i_job,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output svd_pkg::t_out_word      o_out
);
    localparam int TW = $clog2(RING_ROWS);
    localparam int EW = $clog2(EMIT_ROWS);

    svd_pkg::t_back_state r_st, n_st;

    logic [svd_pkg::NSTATES-1:0] r_ring [RING_ROWS];
    logic [svd_pkg::NSTATES-1:0] r_rd;
    logic r_reo [EMIT_ROWS];
    logic r_reo_rd;

    logic [TW-1:0] r_wr_row, r_row, r_t;
    logic [5:0]    r_state;
    logic [EW-1:0] r_k;
    logic          r_ov;
    svd_pkg::t_out_word r_out;

    logic [TW-1:0] w_wr_inc, w_rd_addr, w_reo_idx;
    logic          w_d, w_load, w_last;

    assign w_wr_inc  = (r_wr_row == TW'(RING_ROWS - 1)) ? '0 : r_wr_row + TW'(1);
    assign w_rd_addr = (r_row == '0) ? TW'(RING_ROWS - 1) : r_row - TW'(1);
    assign w_d       = r_rd[r_state];
    assign w_reo_idx = TW'(RING_ROWS - 1) - r_t;
    assign w_last    = (r_k == EW'(EMIT_ROWS - 1));
    assign w_load    = (r_st == svd_pkg::B_EM_LOAD) && (!r_ov || !i_out_stall);

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        case (r_st)
            svd_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (i_job.trig) n_st = svd_pkg::B_TB_ADDR;
                end
            end
            svd_pkg::B_TB_ADDR: n_st = svd_pkg::B_TB_DATA;
            svd_pkg::B_TB_DATA:
                n_st = (r_t == TW'(RING_ROWS - 1)) ? svd_pkg::B_EM_ADDR : svd_pkg::B_TB_ADDR;
            svd_pkg::B_EM_ADDR: n_st = svd_pkg::B_EM_LOAD;
            svd_pkg::B_EM_LOAD:
                if (w_load) n_st = w_last ? svd_pkg::B_IDLE : svd_pkg::B_EM_ADDR;
            default: n_st = svd_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= svd_pkg::B_IDLE;
            r_wr_row <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_st <= n_st;
            if (o_pop) r_wr_row <= w_wr_inc;
            if (w_load)                 r_ov <= 1'b1;
            else if (r_ov && !i_out_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            svd_pkg::B_IDLE: begin
                r_row   <= w_wr_inc;
                r_state <= i_job.best;
                r_t     <= '0;
                r_k     <= '0;
            end
            svd_pkg::B_TB_ADDR: r_row <= w_rd_addr;
            svd_pkg::B_TB_DATA: begin
                r_state <= {w_d, r_state[5:1]};
                r_t     <= r_t + TW'(1);
            end
            svd_pkg::B_EM_LOAD: if (w_load) r_k <= r_k + EW'(1);
            default: ;
        endcase
        if (w_load) begin
            r_out.decoded_bit    <= r_reo_rd;
            r_out.last_of_window <= w_last;
        end
    end

    // survivor ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (o_pop) r_ring[r_wr_row] <= i_job.row;
        r_rd <= r_ring[w_rd_addr];
    end

    // reorder buffer turns the backward trace into oldest-first order
    always_ff @(posedge i_clk) begin
        if (r_st == svd_pkg::B_TB_DATA && r_t >= TW'(RING_ROWS - EMIT_ROWS))
            r_reo[w_reo_idx[EW-1:0]] <= w_d;
        r_reo_rd <= r_reo[r_k];
    end
endmodule
`default_nettype wire

// ----- sv/soft_viterbi_decoder_k7.sv -----
`default_nettype none
// Rate-1/2, 64-state soft-decision Viterbi decoder. Each input word carries
// two 4-bit soft values and a record flag; the ACS front end takes a word
// through acceptance, an ACS step, a registered min tree and a normalize
// step, and holds in normalize while a recorded row finds the queue full.
// Recorded decision rows go through a two-entry queue to the traceback
// engine, which owns the survivor ring. Once the ring is full, and every
// min(OUTPUT_CHUNK, RING_ROWS) rows after, it traces the whole ring from
// the best state (ring read is registered), then emits the oldest
// min(OUTPUT_CHUNK, RING_ROWS) bits oldest first, last_of_window marking
// the final one. The front keeps decoding while a traceback runs until
// the queue fills. No clearing pass follows reset.
module soft_viterbi_decoder_k7 #(
    parameter int RING_ROWS    = 128,
    parameter int OUTPUT_CHUNK = 64,
    parameter int METRIC_BITS  = 11
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire svd_pkg::t_in_word  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output svd_pkg::t_out_word      o_out
);
    // a run never emits more rows than the ring holds
    localparam int EMIT_ROWS = (OUTPUT_CHUNK < RING_ROWS) ? OUTPUT_CHUNK : RING_ROWS;

    svd_pkg::t_push w_push;
    svd_pkg::t_job  w_job;
    logic w_full, w_qv, w_pop;

    svd_front #(
        .METRIC_BITS (METRIC_BITS),
        .RING_ROWS   (RING_ROWS),
        .EMIT_ROWS   (EMIT_ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_q_full   (w_full),
        .o_push     (w_push)
    );

    svd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qv),
        .o_job   (w_job)
    );

    svd_back #(
        .RING_ROWS (RING_ROWS),
        .EMIT_ROWS (EMIT_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_qv),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

// ----- sv/svd_chk.sv -----
`default_nettype none
`include "soft_viterbi_decoder_k7_defines.svh"
module svd_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire svd_pkg::t_out_word o_out
);
    logic w_held;

    assign w_held = o_out_valid && i_out_stall;

    // reset empties the output register and frees the front end
    `SVD_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n, !o_out_valid)
    `SVD_ASSERT_ALWAYS(a_rst_in, i_clk, !i_rst_n, !o_in_stall)
    // a held word stays put
    `SVD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_held, o_out_valid && $stable(o_out))
endmodule

bind soft_viterbi_decoder_k7 svd_chk u_svd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
`default_nettype wire
